// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the tokenizer rtl
// no dependencies; compiled away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// expression must never be true
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== hw/rtl/cst_pkg.sv =====
// types, constants and character classes for the c subset tokenizer
// no dependencies
`timescale 1ns / 1ps

package cst_pkg;

   // source limits
   localparam int MAX_SOURCE_BYTES = 1048576;
   localparam int MAX_LINES        = 65535;

   localparam int OFFSET_W = 20;
   localparam int LINE_W   = 16;
   localparam int KIND_W   = 5;

   // saturation points for offset and line
   localparam logic [OFFSET_W-1:0] POS_CAP =
      (MAX_SOURCE_BYTES - 1 < 1048575) ? OFFSET_W'(MAX_SOURCE_BYTES - 1) : 20'hFFFFF;
   localparam logic [LINE_W-1:0] LINE_CAP =
      (MAX_LINES < 65535) ? LINE_W'(MAX_LINES) : 16'hFFFF;

   // bytes skipped after the 'i' of #include, beyond the 'i' itself
   localparam logic [2:0] INCLUDE_SKIP_LEFT = 3'd6;
   localparam logic [OFFSET_W-1:0] INCLUDE_LEN = 20'd8;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // lexing modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_HASH,
      MODE_SKIP
   } mode_type;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_INT     = 5'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR    = 5'd1;
   localparam logic [KIND_W-1:0] KIND_RETURN  = 5'd2;
   localparam logic [KIND_W-1:0] KIND_FOR     = 5'd3;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd4;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd5;
   localparam logic [KIND_W-1:0] KIND_STRING  = 5'd6;
   localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd7;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd8;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd9;
   localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd10;
   localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd11;
   localparam logic [KIND_W-1:0] KIND_LT      = 5'd12;
   localparam logic [KIND_W-1:0] KIND_GT      = 5'd13;
   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd14;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd15;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd16;
   localparam logic [KIND_W-1:0] KIND_STAR    = 5'd17;
   localparam logic [KIND_W-1:0] KIND_INCLUDE = 5'd18;
   localparam logic [KIND_W-1:0] KIND_EOF     = 5'd19;
   localparam logic [KIND_W-1:0] KIND_BAD     = 5'd20;
   localparam logic [KIND_W-1:0] KIND_UNTERM  = 5'd21;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_HASH  = "#";
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_I     = "i";

   // keyword spellings, last byte in the low bits
   localparam logic [23:0] KW_INT    = "int";
   localparam logic [23:0] KW_FOR    = "for";
   localparam logic [31:0] KW_CHAR   = "char";
   localparam logic [47:0] KW_RETURN = "return";

   // one result item
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] start_offset;
      logic [OFFSET_W-1:0] text_length;
      logic [LINE_W-1:0]   line_no;
      logic                last_of_run;
   } tok_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   // single character punctuation; valid flag in the top bit
   function automatic logic [KIND_W:0] punct_lookup(input logic [7:0] c);
      logic [KIND_W:0] r;
      case (c)
         ";": r = {1'b1, KIND_SEMI};
         "(": r = {1'b1, KIND_LPAREN};
         ")": r = {1'b1, KIND_RPAREN};
         "{": r = {1'b1, KIND_LBRACE};
         "}": r = {1'b1, KIND_RBRACE};
         "<": r = {1'b1, KIND_LT};
         ">": r = {1'b1, KIND_GT};
         "=": r = {1'b1, KIND_ASSIGN};
         "+": r = {1'b1, KIND_PLUS};
         "-": r = {1'b1, KIND_MINUS};
         "*": r = {1'b1, KIND_STAR};
         default: r = '0;
      endcase
      return r;
   endfunction

   // identifier or keyword from length and the last six bytes
   function automatic logic [KIND_W-1:0] word_kind(input logic [OFFSET_W-1:0] len,
                                                   input logic [47:0] win);
      logic [KIND_W-1:0] k;
      k = KIND_IDENT;
      if (len == 20'd3 && win[23:0] == KW_INT)
         k = KIND_INT;
      else if (len == 20'd4 && win[31:0] == KW_CHAR)
         k = KIND_CHAR;
      else if (len == 20'd6 && win == KW_RETURN)
         k = KIND_RETURN;
      else if (len == 20'd3 && win[23:0] == KW_FOR)
         k = KIND_FOR;
      return k;
   endfunction

endpackage

// ===== hw/rtl/c_subset_byte_tokenizer_unit.sv =====
// Streaming tokenizer for a small C subset.
//
// req_ channel: one source byte per item (req_ch), or an end marker
// (req_is_end = 1) that flushes any pending token and emits end of file.
// rsp_ channel: token items carrying kind, start offset, text length,
// line number and last_of_run, which marks the final token of one input.
// An input item gives zero, one or two tokens.
//
// Each accepted byte updates the lexer state in the same cycle and its
// tokens are written into a four-entry result queue. One byte is taken
// every cycle while the queue has room for two tokens, so throughput is
// one item per cycle as long as the receiver drains tokens as fast as
// they are made; the queue depth is what sets the stall point.
// Reset returns the lexer to line 1, offset 0, and empties the queue.
// When rsp_stall is high the head token holds; once the queue holds more
// than two tokens req_stall is raised.
// Depends on cst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c_subset_byte_tokenizer_unit
   import cst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_ch,
   input  logic                req_is_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [OFFSET_W-1:0] rsp_start_offset,
   output logic [OFFSET_W-1:0] rsp_text_length,
   output logic [LINE_W-1:0]   rsp_line_no,
   output logic                rsp_last_of_run
);

   // lexer state
   mode_type            mode_ff,  mode_in;
   logic [OFFSET_W-1:0] pos_ff,   pos_in;
   logic [LINE_W-1:0]   line_ff,  line_in;
   logic [OFFSET_W-1:0] start_ff, start_in;
   logic [47:0]         win_ff,   win_in;
   logic [2:0]          skip_ff,  skip_in;

   // result queue
   tok_result_type      fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   logic req_accept, rsp_accept;

   // idle byte decode
   logic [KIND_W:0]     punct;
   logic                idle_emit, idle_bump, idle_start_set, idle_win_set;
   logic [KIND_W-1:0]   idle_kind;
   mode_type            idle_mode;
   logic [OFFSET_W-1:0] idle_start;

   // token emission
   logic                a_v, b_v, bump;
   logic [KIND_W-1:0]   a_kind, b_kind;
   logic [OFFSET_W-1:0] a_start, a_len, b_start, b_len;
   logic [OFFSET_W-1:0] tok_len;
   logic [2:0]          skip_dec;
   logic [1:0]          n_push;
   tok_result_type      res0, res1;

   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (count_ff > RSP_CNT_W'(RSP_DEPTH - 2));

   assign tok_len  = pos_ff - start_ff;
   assign skip_dec = (skip_ff != 3'd0) ? skip_ff - 3'd1 : 3'd0;

   // what a byte does when no token is pending
   always_comb begin
      punct          = punct_lookup(req_ch);
      idle_emit      = 1'b0;
      idle_kind      = KIND_BAD;
      idle_mode      = MODE_IDLE;
      idle_bump      = 1'b0;
      idle_start_set = 1'b0;
      idle_start     = pos_ff;
      idle_win_set   = 1'b0;
      if (req_ch == CH_SPACE || req_ch == CH_CR || req_ch == CH_TAB) begin
         idle_emit = 1'b0;
      end else if (req_ch == CH_LF) begin
         idle_bump = 1'b1;
      end else if (punct[KIND_W]) begin
         idle_emit = 1'b1;
         idle_kind = punct[KIND_W-1:0];
      end else if (req_ch == CH_SLASH) begin
         idle_mode      = MODE_SLASH;
         idle_start_set = 1'b1;
      end else if (req_ch == CH_HASH) begin
         idle_mode      = MODE_HASH;
         idle_start_set = 1'b1;
      end else if (req_ch == CH_QUOTE) begin
         idle_mode      = MODE_STRING;
         idle_start_set = 1'b1;
         idle_start     = (pos_ff < POS_CAP) ? pos_ff + 20'd1 : POS_CAP;
      end else if (is_digit(req_ch)) begin
         idle_mode      = MODE_NUMBER;
         idle_start_set = 1'b1;
      end else if (is_alpha(req_ch)) begin
         idle_mode      = MODE_IDENT;
         idle_start_set = 1'b1;
         idle_win_set   = 1'b1;
      end else begin
         idle_emit = 1'b1;
         idle_kind = KIND_BAD;
      end
   end

   // next lexer state and up to two tokens
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = (pos_ff < POS_CAP) ? pos_ff + 20'd1 : pos_ff;
      start_in = start_ff;
      win_in   = win_ff;
      skip_in  = skip_ff;
      bump     = 1'b0;
      a_v      = 1'b0;
      a_kind   = KIND_BAD;
      a_start  = start_ff;
      a_len    = tok_len;
      b_v      = 1'b0;
      b_kind   = idle_kind;
      b_start  = pos_ff;
      b_len    = 20'd1;
      if (req_is_end) begin
         // flush the pending token, then end of file
         case (mode_ff)
            MODE_IDENT: begin
               a_v    = 1'b1;
               a_kind = word_kind(tok_len, win_ff);
            end
            MODE_NUMBER: begin
               a_v    = 1'b1;
               a_kind = KIND_NUMBER;
            end
            MODE_STRING: begin
               a_v    = 1'b1;
               a_kind = KIND_UNTERM;
            end
            MODE_SLASH: begin
               a_v    = 1'b1;
               a_kind = KIND_BAD;
               a_len  = 20'd1;
            end
            default: begin
               a_v = 1'b0;
            end
         endcase
         b_v      = 1'b1;
         b_kind   = KIND_EOF;
         b_start  = pos_ff;
         b_len    = 20'd0;
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         win_in   = '0;
         skip_in  = '0;
      end else begin
         b_v = 1'b0;
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(req_ch) || is_digit(req_ch)) begin
                  win_in = {win_ff[39:0], req_ch};
               end else begin
                  a_v    = 1'b1;
                  a_kind = word_kind(tok_len, win_ff);
                  b_v    = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (!is_digit(req_ch)) begin
                  a_v    = 1'b1;
                  a_kind = KIND_NUMBER;
                  b_v    = 1'b1;
               end
            end
            MODE_STRING: begin
               if (req_ch == CH_QUOTE) begin
                  a_v     = 1'b1;
                  a_kind  = KIND_STRING;
                  mode_in = MODE_IDLE;
               end else if (req_ch == CH_LF) begin
                  bump = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (req_ch == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  a_v    = 1'b1;
                  a_kind = KIND_BAD;
                  a_len  = 20'd1;
                  b_v    = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (req_ch == CH_LF) begin
                  bump    = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_HASH: begin
               if (req_ch == CH_I) begin
                  a_v     = 1'b1;
                  a_kind  = KIND_INCLUDE;
                  a_len   = INCLUDE_LEN;
                  skip_in = INCLUDE_SKIP_LEFT;
                  mode_in = MODE_SKIP;
               end else begin
                  b_v = 1'b1;
               end
            end
            MODE_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 3'd0) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               b_v = 1'b1;
            end
         endcase
         // b_v here means the byte is lexed from idle
         if (b_v) begin
            mode_in = idle_mode;
            bump    = idle_bump;
            if (idle_start_set) begin
               start_in = idle_start;
            end
            if (idle_win_set) begin
               win_in = {40'd0, req_ch};
            end
            b_v = idle_emit;
         end
      end
      line_in = line_ff;
      if (req_is_end) begin
         line_in = 16'd1;
      end else if (bump && line_ff < LINE_CAP) begin
         line_in = line_ff + 16'd1;
      end
   end

   // pack the tokens in order, marking the last one
   always_comb begin
      res0.kind         = a_v ? a_kind : b_kind;
      res0.start_offset = a_v ? a_start : b_start;
      res0.text_length  = a_v ? a_len : b_len;
      res0.line_no      = line_ff;
      res0.last_of_run  = !(a_v && b_v);
      res1.kind         = b_kind;
      res1.start_offset = b_start;
      res1.text_length  = b_len;
      res1.line_no      = line_ff;
      res1.last_of_run  = 1'b1;
      n_push            = req_accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(rsp_accept);
      count_in  = count_ff + RSP_CNT_W'(n_push) - RSP_CNT_W'(rsp_accept);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         line_ff   <= 16'd1;
         start_ff  <= '0;
         win_ff    <= '0;
         skip_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            line_ff  <= line_in;
            start_ff <= start_in;
            win_ff   <= win_in;
            skip_ff  <= skip_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_push == 2'd2) begin
         fifo_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= res1;
      end
   end

   // head of queue drives the result port
   assign rsp_kind         = fifo_ff[rd_ptr_ff].kind;
   assign rsp_start_offset = fifo_ff[rd_ptr_ff].start_offset;
   assign rsp_text_length  = fifo_ff[rd_ptr_ff].text_length;
   assign rsp_line_no      = fifo_ff[rd_ptr_ff].line_no;
   assign rsp_last_of_run  = fifo_ff[rd_ptr_ff].last_of_run;

   // checks
   `ASSERT_NEVER(a_queue_bound, clock, reset, count_ff > RSP_CNT_W'(RSP_DEPTH), "queue overflow")
   `ASSERT_NEVER(a_line_nonzero, clock, reset, line_ff == 16'd0, "line number is zero")
   `ASSERT_IMPLIES(a_skip_mode, clock, reset, skip_ff != 3'd0, mode_ff == MODE_SKIP, "skip count outside skip mode")
   `ASSERT_IMPLIES(a_push_room, clock, reset, n_push != 2'd0, count_ff <= RSP_CNT_W'(RSP_DEPTH - 2), "push without room")

endmodule

// ===== bench/tb_c_subset_byte_tokenizer_unit.sv =====
// testbench for c_subset_byte_tokenizer_unit: directed byte script, then random
// source fragments under several idle/stall mixes
// depends on cst_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module tb_c_subset_byte_tokenizer_unit;
   import cst_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int CYCLE_LIMIT   = 50_000;
   localparam int DIRECTED_ROWS = 28;
   localparam int PRINT_LIMIT   = 100;

   // byte pools for random source text; blanks sit in the top four bytes
   localparam logic [8*11-1:0] PUNCT_CHARS = ";(){}<>=+-*";
   localparam logic [8*15-1:0] SEPARATORS  = {CH_SPACE, CH_TAB, CH_CR, CH_LF, PUNCT_CHARS};
   localparam logic [8*63-1:0] WORD_CHARS  =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

   localparam tok_result_type NO_TOK = '0;

   typedef struct packed {
      logic       is_end;
      logic [7:0] ch;
   } src_item_type;

   // one directed row; tok is only meaningful when typed is set
   typedef struct packed {
      logic [7:0]     ch;
      logic           is_end;
      logic           typed;
      tok_result_type tok;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_ch = 8'h00;
   logic                req_is_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [OFFSET_W-1:0] rsp_start_offset;
   logic [OFFSET_W-1:0] rsp_text_length;
   logic [LINE_W-1:0]   rsp_line_no;
   logic                rsp_last_of_run;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;

   tok_result_type pending_tokens[$];
   tok_result_type want_tok;
   src_item_type   frag_items[$];

   string keyword_text [4] = '{"int", "char", "return", "for"};

   // lexer shadow state
   mode_type            scan_mode;
   logic [OFFSET_W-1:0] scan_pos;
   logic [LINE_W-1:0]   scan_line;
   logic [OFFSET_W-1:0] scan_start;
   logic [47:0]         scan_window;
   logic [2:0]          scan_skip;
   tok_result_type      step_tokens [2];
   int                  step_count;

   // directed script: extremes, lone slash, include skip, strings, end cases
   script_row_type script [DIRECTED_ROWS] = '{
      {8'h00, 1'b0, 1'b1, KIND_BAD, 20'd0, 20'd1, 16'd1, 1'b1},
      {8'hFF, 1'b0, 1'b1, KIND_BAD, 20'd1, 20'd1, 16'd1, 1'b1},
      {"/", 1'b0, 1'b0, NO_TOK},
      {"i", 1'b0, 1'b1, KIND_BAD, 20'd2, 20'd1, 16'd1, 1'b1},
      {"n", 1'b0, 1'b0, NO_TOK},
      {"t", 1'b0, 1'b0, NO_TOK},
      {"(", 1'b0, 1'b0, NO_TOK},
      {"#", 1'b0, 1'b0, NO_TOK},
      {"i", 1'b0, 1'b1, KIND_INCLUDE, 20'd7, 20'd8, 16'd1, 1'b1},
      {")", 1'b0, 1'b0, NO_TOK},
      {CH_LF, 1'b0, 1'b0, NO_TOK},
      {CH_QUOTE, 1'b0, 1'b0, NO_TOK},
      {"/", 1'b0, 1'b0, NO_TOK},
      {"#", 1'b0, 1'b0, NO_TOK},
      {"i", 1'b0, 1'b0, NO_TOK},
      {CH_QUOTE, 1'b0, 1'b0, NO_TOK},
      {CH_LF, 1'b0, 1'b0, NO_TOK},
      {"a", 1'b0, 1'b0, NO_TOK},
      {CH_QUOTE, 1'b0, 1'b0, NO_TOK},
      {"9", 1'b0, 1'b0, NO_TOK},
      {8'h00, 1'b1, 1'b0, NO_TOK},
      {CH_QUOTE, 1'b0, 1'b0, NO_TOK},
      {8'hFF, 1'b1, 1'b0, NO_TOK},
      {8'h5A, 1'b1, 1'b1, KIND_EOF, 20'd0, 20'd0, 16'd1, 1'b1},
      {"#", 1'b0, 1'b0, NO_TOK},
      {"x", 1'b0, 1'b0, NO_TOK},
      {"/", 1'b0, 1'b0, NO_TOK},
      {8'h00, 1'b1, 1'b0, NO_TOK}
   };

   c_subset_byte_tokenizer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_is_end       (req_is_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_text_length  (rsp_text_length),
      .rsp_line_no      (rsp_line_no),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- lexer shadow

   function automatic void scan_clear();
      scan_mode   = MODE_IDLE;
      scan_pos    = '0;
      scan_line   = 16'd1;
      scan_start  = '0;
      scan_window = '0;
      scan_skip   = '0;
   endfunction

   function automatic void scan_emit(input logic [KIND_W-1:0] k,
                                     input logic [OFFSET_W-1:0] start,
                                     input logic [OFFSET_W-1:0] len);
      if (step_count < 2) begin
         step_tokens[step_count] = '{kind: k, start_offset: start, text_length: len,
                                     line_no: scan_line, last_of_run: 1'b0};
         step_count++;
      end
   endfunction

   function automatic void scan_next_line();
      if (scan_line < LINE_CAP)
         scan_line++;
   endfunction

   function automatic logic digit_byte(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic letter_byte(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   // punctuation kinds follow the order of PUNCT_CHARS, first char is the semicolon
   function automatic void punct_of(input logic [7:0] c, output logic hit,
                                    output logic [KIND_W-1:0] k);
      hit = 1'b0;
      k = KIND_SEMI;
      for (int i = 0; i < 11; i++) begin
         if (PUNCT_CHARS[8*(10-i) +: 8] == c) begin
            hit = 1'b1;
            k = KIND_SEMI + KIND_W'(i);
         end
      end
   endfunction

   // word closes: keyword only on exact length and matching tail bytes
   function automatic void scan_word_done();
      logic [OFFSET_W-1:0] len;
      logic [KIND_W-1:0]   k;
      len = scan_pos - scan_start;
      k = KIND_IDENT;
      if (len == 20'd3 && scan_window[23:0] == KW_INT)
         k = KIND_INT;
      else if (len == 20'd4 && scan_window[31:0] == KW_CHAR)
         k = KIND_CHAR;
      else if (len == 20'd6 && scan_window == KW_RETURN)
         k = KIND_RETURN;
      else if (len == 20'd3 && scan_window[23:0] == KW_FOR)
         k = KIND_FOR;
      scan_emit(k, scan_start, len);
   endfunction

   // a byte seen with no token open
   function automatic void scan_idle(input logic [7:0] c);
      logic              hit;
      logic [KIND_W-1:0] pk;
      punct_of(c, hit, pk);
      scan_mode = MODE_IDLE;
      if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
      end else if (c == CH_LF) begin
         scan_next_line();
      end else if (hit) begin
         scan_emit(pk, scan_pos, 20'd1);
      end else if (c == CH_SLASH) begin
         scan_mode = MODE_SLASH;
         scan_start = scan_pos;
      end else if (c == CH_HASH) begin
         scan_mode = MODE_HASH;
         scan_start = scan_pos;
      end else if (c == CH_QUOTE) begin
         scan_mode = MODE_STRING;
         scan_start = (scan_pos < POS_CAP) ? scan_pos + 20'd1 : POS_CAP;
      end else if (digit_byte(c)) begin
         scan_mode = MODE_NUMBER;
         scan_start = scan_pos;
      end else if (letter_byte(c)) begin
         scan_mode = MODE_IDENT;
         scan_start = scan_pos;
         scan_window = {40'd0, c};
      end else begin
         scan_emit(KIND_BAD, scan_pos, 20'd1);
      end
   endfunction

   // tokens caused by one accepted item, into step_tokens
   function automatic void scan_byte(input logic [7:0] c, input logic is_end);
      step_count = 0;
      if (is_end) begin
         case (scan_mode)
            MODE_IDENT:  scan_word_done();
            MODE_NUMBER: scan_emit(KIND_NUMBER, scan_start, scan_pos - scan_start);
            MODE_STRING: scan_emit(KIND_UNTERM, scan_start, scan_pos - scan_start);
            MODE_SLASH:  scan_emit(KIND_BAD, scan_start, 20'd1);
            default: begin
            end
         endcase
         scan_emit(KIND_EOF, scan_pos, 20'd0);
         scan_clear();
      end else begin
         case (scan_mode)
            MODE_IDENT: begin
               if (letter_byte(c) || digit_byte(c)) begin
                  scan_window = {scan_window[39:0], c};
               end else begin
                  scan_word_done();
                  scan_idle(c);
               end
            end
            MODE_NUMBER: begin
               if (!digit_byte(c)) begin
                  scan_emit(KIND_NUMBER, scan_start, scan_pos - scan_start);
                  scan_idle(c);
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  scan_emit(KIND_STRING, scan_start, scan_pos - scan_start);
                  scan_mode = MODE_IDLE;
               end else if (c == CH_LF) begin
                  scan_next_line();
               end
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  scan_mode = MODE_COMMENT;
               end else begin
                  scan_emit(KIND_BAD, scan_start, 20'd1);
                  scan_idle(c);
               end
            end
            MODE_COMMENT: begin
               if (c == CH_LF) begin
                  scan_next_line();
                  scan_mode = MODE_IDLE;
               end
            end
            MODE_HASH: begin
               if (c == CH_I) begin
                  scan_emit(KIND_INCLUDE, scan_start, INCLUDE_LEN);
                  scan_skip = INCLUDE_SKIP_LEFT;
                  scan_mode = MODE_SKIP;
               end else begin
                  scan_idle(c);
               end
            end
            MODE_SKIP: begin
               if (scan_skip != 3'd0)
                  scan_skip--;
               if (scan_skip == 3'd0)
                  scan_mode = MODE_IDLE;
            end
            default: scan_idle(c);
         endcase
         if (scan_pos < POS_CAP)
            scan_pos++;
      end
      if (step_count > 0)
         step_tokens[step_count-1].last_of_run = 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_LIMIT)
         $display("%0t: token %s mismatch: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // compare each delivered token with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            report_mismatch("arrival (none expected), kind", rsp_kind, -1);
         end else begin
            want_tok = pending_tokens.pop_front();
            if (rsp_kind != want_tok.kind)
               report_mismatch("kind", rsp_kind, want_tok.kind);
            if (rsp_start_offset != want_tok.start_offset)
               report_mismatch("start_offset", rsp_start_offset, want_tok.start_offset);
            if (rsp_text_length != want_tok.text_length)
               report_mismatch("text_length", rsp_text_length, want_tok.text_length);
            if (rsp_line_no != want_tok.line_no)
               report_mismatch("line_no", rsp_line_no, want_tok.line_no);
            if (rsp_last_of_run != want_tok.last_of_run)
               report_mismatch("last_of_run", rsp_last_of_run, want_tok.last_of_run);
         end
      end
   end

   // random receiver stall
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // present one item, wait for it to be taken, then record its tokens
   task automatic send_item(input logic [7:0] c, input logic is_end, input logic typed,
                            input tok_result_type typed_tok);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_ch     <= c;
      req_is_end <= is_end;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      scan_byte(c, is_end);
      if (typed) begin
         pending_tokens.insert(pending_tokens.size(), typed_tok);
      end else begin
         for (int i = 0; i < step_count; i++)
            pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
      end
      @(negedge clock);
   endtask

   // sender goes quiet until every expected token is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_tokens.size() != 0)
         @(negedge clock);
   endtask

   function automatic void push_byte(input logic [7:0] b);
      frag_items.insert(frag_items.size(), {1'b0, b});
   endfunction

   function automatic void push_end();
      frag_items.insert(frag_items.size(), {1'b1, 8'($urandom)});
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick_word_byte(input logic lead);
      int k;
      k = lead ? $urandom_range(62, 10) : $urandom_range(62);
      return WORD_CHARS[8*k +: 8];
   endfunction

   function automatic logic [7:0] pick_separator();
      int k;
      k = $urandom_range(14);
      return SEPARATORS[8*k +: 8];
   endfunction

   function automatic logic [7:0] pick_any();
      return 8'($urandom_range(255));
   endfunction

   task automatic send_fragment();
      foreach (frag_items[i])
         send_item(frag_items[i].ch, frag_items[i].is_end, 1'b0, NO_TOK);
   endtask

   // one piece of source text, mostly well formed, sometimes noise or cut short
   task automatic build_fragment();
      int         pick;
      int         n;
      logic [7:0] b;
      frag_items.delete();
      pick = $urandom_range(13);
      case (pick)
         0, 13: begin
            push_text(keyword_text[$urandom_range(3)]);
            push_byte(pick_separator());
         end
         1: begin
            // keyword spelling, sometimes buried in a longer word
            if ($urandom_range(1))
               push_byte(pick_word_byte(1'b1));
            push_text(keyword_text[$urandom_range(3)]);
            if ($urandom_range(1))
               push_byte(pick_word_byte(1'b0));
            push_byte(pick_separator());
         end
         2: begin
            push_byte(pick_word_byte(1'b1));
            n = $urandom_range(8);
            repeat (n) push_byte(pick_word_byte(1'b0));
            push_byte(pick_separator());
         end
         3: begin
            n = $urandom_range(5, 1);
            repeat (n) push_byte(8'h30 + 8'($urandom_range(9)));
            push_byte(pick_separator());
         end
         4: begin
            push_byte(CH_QUOTE);
            n = $urandom_range(6);
            repeat (n) begin
               b = pick_any();
               push_byte(b == CH_QUOTE ? CH_LF : b);
            end
            push_byte(CH_QUOTE);
         end
         5: begin
            n = $urandom_range(10);
            push_byte(PUNCT_CHARS[8*n +: 8]);
         end
         6: begin
            n = $urandom_range(14, 11);
            push_byte(SEPARATORS[8*n +: 8]);
         end
         7: begin
            push_byte(CH_SLASH);
            push_byte(CH_SLASH);
            n = $urandom_range(6);
            repeat (n) begin
               b = pick_any();
               push_byte(b == CH_LF ? "x" : b);
            end
            push_byte(CH_LF);
         end
         8: begin
            push_byte(CH_HASH);
            push_byte(CH_I);
            repeat (6) push_byte(pick_any());
         end
         9: begin
            push_byte(CH_HASH);
            b = pick_any();
            push_byte(b == CH_I ? "j" : b);
         end
         10: begin
            push_byte(CH_SLASH);
            b = pick_any();
            push_byte(b == CH_SLASH ? "*" : b);
         end
         11: push_byte(pick_any());
         default: push_end();
      endcase
      // now and then the source closes in the middle of the fragment
      if (frag_items.size() > 1 && $urandom_range(9) == 0) begin
         n = $urandom_range(frag_items.size() - 1, 1);
         while (frag_items.size() > n)
            void'(frag_items.pop_back());
         push_end();
      end
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
      int sent;
      sent = 0;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      while (sent < count) begin
         build_fragment();
         send_fragment();
         sent += frag_items.size();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      scan_clear();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_item(script[i].ch, script[i].is_end, script[i].typed, script[i].tok);
      wait_drained();

      random_phase(58, 0, 100);
      wait_drained();
      random_phase(0, 58, 100);
      wait_drained();
      random_phase(7, 7, 100);
      wait_drained();
      random_phase(0, 0, 100);
      send_item(8'h00, 1'b1, 1'b0, NO_TOK);
      wait_drained();
      repeat (8) @(negedge clock);

      if (pending_tokens.size() != 0)
         report_mismatch("count left undelivered", 0, pending_tokens.size());
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cst_pkg.sv
hw/rtl/c_subset_byte_tokenizer_unit.sv
bench/tb_c_subset_byte_tokenizer_unit.sv
